>>> rtl/bse_pkg.sv
// bse_pkg: types, constants and state codes of the binary search engine.
// Used by binary_search_engine; depends on nothing.
package bse_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BND_W       = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = 10;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = 11;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_FINISH
	} state_t;

endpackage

>>> rtl/bse_ram.sv
// bse_ram: generic single-port RAM with registered read.
// Holds the sorted table of binary_search_engine; depends on nothing.
module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                           wdata,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/binary_search_engine.sv
// binary_search_engine: top level, sequencer and output register.
// Depends on bse_pkg and bse_ram.
//
// A write request stores one entry in a single-port table RAM and
// gives no result. A search request runs one probe per cycle: the table read
// for a probe is issued in the cycle before its compare, and the next midpoint
// goes to the RAM address in the cycle of the compare. A search over
// entry_count entries takes up to floor(log2(entry_count)) + 1 probes, and
// an empty table takes none. The block takes one request at a time; the
// next one is accepted once the result of the last search has been loaded,
// even while that result still waits at the output.
module binary_search_engine
	import bse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_req,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [BND_W-1:0]        lo_q, lo_d;
	logic [BND_W-1:0]        hi_q, hi_d;
	logic [TBL_AW-1:0]       mid_q, mid_d;
	logic signed [VAL_W-1:0] key_q, key_d;
	logic                    found_q, found_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic                    out_valid_q;
	rsp_t                    out_rsp_q;

	logic                    ram_we;
	logic [TBL_AW-1:0]       ram_addr;
	logic [VAL_W-1:0]        ram_rdata;
	logic signed [VAL_W-1:0] entry;
	logic [BND_W-1:0]        n_used;
	logic [BND_W-1:0]        nlo, nhi;
	logic [BND_W:0]          mid_sum;
	logic                    accept, out_free, load_out;

	bse_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(in_req.value),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = (state_q == ST_FINISH) && out_free;
	assign entry     = signed'(ram_rdata);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	assign n_used = (32'(count_q) > 32'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH) : BND_W'(count_q);

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		key_d    = key_q;
		found_d  = found_q;
		pos_d    = pos_q;
		ram_we   = 1'b0;
		ram_addr = mid_q;
		nlo      = lo_q;
		nhi      = hi_q;
		mid_sum  = '0;
		case (state_q)
			ST_IDLE: begin
				nlo     = '0;
				nhi     = n_used;
				mid_sum = ({1'b0, nlo} + {1'b0, nhi} - 1'b1) >> 1;
				if (accept) begin
					if (in_req.op == OP_WRITE) begin
						ram_we   = (32'(in_req.position) < 32'(TABLE_DEPTH));
						ram_addr = TBL_AW'(in_req.position);
					end else begin
						key_d   = in_req.value;
						found_d = 1'b0;
						pos_d   = '0;
						lo_d    = nlo;
						hi_d    = nhi;
						if (nlo < nhi) begin
							mid_d    = TBL_AW'(mid_sum);
							ram_addr = TBL_AW'(mid_sum);
							state_d  = ST_PROBE;
						end else begin
							state_d = ST_FINISH;
						end
					end
				end
			end
			ST_PROBE: begin
				if (entry < key_q) begin
					nlo = BND_W'(mid_q) + 1'b1;
				end else begin
					nhi = BND_W'(mid_q);
				end
				mid_sum = ({1'b0, nlo} + {1'b0, nhi} - 1'b1) >> 1;
				if (entry == key_q) begin
					found_d = 1'b1;
					pos_d   = POS_W'(mid_q);
					state_d = ST_FINISH;
				end else if (nlo < nhi) begin
					lo_d     = nlo;
					hi_d     = nhi;
					mid_d    = TBL_AW'(mid_sum);
					ram_addr = TBL_AW'(mid_sum);
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		key_q   <= key_d;
		found_q <= found_d;
		pos_q   <= pos_d;
		if (load_out) begin
			out_rsp_q.found          <= found_q;
			out_rsp_q.match_position <= pos_q;
		end
	end

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.found |-> out_rsp.match_position == '0)
		else $error("miss result carries a nonzero position");

	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> lo_q < hi_q && BND_W'(mid_q) >= lo_q && BND_W'(mid_q) < hi_q)
		else $error("probe midpoint outside bounds");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_req.op == OP_SEARCH |=> state_q != ST_IDLE)
		else $error("accepted search did not start");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid && out_rsp.found == $past(found_q))
		else $error("result register not loaded");

endmodule

>>> dv/binary_search_engine_tb.sv
// Self-checking testbench for binary_search_engine: loads sorted tables, sets the
// entry count and checks each search answer against a binary search kept in a class.
// Depends on bse_pkg and the binary_search_engine RTL.
`timescale 1ns / 1ps

import bse_pkg::*;

class search_tracker;
	logic signed [VAL_W-1:0] entries [TABLE_DEPTH];
	logic [CNT_W-1:0] entry_count;
	rsp_t pending_results [$];
	int mismatches;

	function rsp_t lookup_key(logic signed [VAL_W-1:0] key);
		int lo;
		int hi;
		int mid;
		rsp_t res;
		lo = 0;
		hi = ((entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count)) - 1;
		res = '0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (entries[mid] == key) begin
				res.found = 1'b1;
				res.match_position = mid[POS_W-1:0];
				return res;
			end
			if (entries[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return res;
	endfunction

	function void note_request(req_t r);
		if (r.op == OP_WRITE)
			entries[r.position] = r.value;
		else
			pending_results.push_back(lookup_key(r.value));
	endfunction

	function void check_result(rsp_t got);
		rsp_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: found %0b pos %0d", got.found,
					got.match_position);
			return;
		end
		want = pending_results.pop_front();
		if (got.found !== want.found || got.match_position !== want.match_position) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected found %0b pos %0d, got found %0b pos %0d",
					want.found, want.match_position, got.found, got.match_position);
		end
	endfunction
endclass

module binary_search_engine_tb;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	req_t             in_req;
	logic             out_valid;
	logic             out_stall = 1'b0;
	rsp_t             out_rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	search_tracker sb;
	int in_idle_max;
	int out_idle_max;
	int out_wait = 0;
	logic hold_off;
	int random_items;
	int big_loads;

	binary_search_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(out_rsp);
				out_wait = $urandom_range(out_idle_max, 0);
			end else if (out_wait > 0) begin
				out_wait = out_wait - 1;
			end
			out_stall <= hold_off || (out_wait > 0);
		end
	end

	task automatic send_req(req_t r);
		int gap;
		gap = $urandom_range(in_idle_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.entry_count = n;
	endtask

	task automatic search_key(logic signed [VAL_W-1:0] key);
		req_t r;
		r.op       = OP_SEARCH;
		r.position = POS_W'($urandom);
		r.value    = key;
		send_req(r);
	endtask

	task automatic write_entry(int pos, logic signed [VAL_W-1:0] val);
		req_t r;
		r.op       = OP_WRITE;
		r.position = pos[POS_W-1:0];
		r.value    = val;
		send_req(r);
	endtask

	// ascending values spread over the whole signed range, with some duplicates
	task automatic load_table(int n, bit pin_ends);
		longint step_max;
		longint cur;
		step_max = 64'd4294967295 / n;
		cur = 64'shFFFF_FFFF_8000_0000;
		if (!pin_ends)
			cur += longint'($urandom_range(32'(step_max), 0));
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom % 8 != 0)
				cur += longint'($urandom_range(32'(step_max), 0));
			if (pin_ends && i == n - 1)
				cur = 64'sd2147483647;
			write_entry(i, cur[VAL_W-1:0]);
		end
	endtask

	function automatic logic signed [VAL_W-1:0] pick_key(int n);
		logic signed [VAL_W-1:0] hit;
		if (n == 0)
			return $urandom;
		hit = sb.entries[$urandom_range(n - 1, 0)];
		case ($urandom % 8)
			4: return ($urandom % 2) ? hit + 1 : hit - 1;
			5: return $urandom;
			6: return ($urandom % 2) ? sb.entries[0] - 1 : sb.entries[n - 1] + 1;
			7: return ($urandom % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			default: return hit;
		endcase
	endfunction

	initial begin
		#(64'd10_000_000);
		$display("binary_search_engine_tb: done, errors");
		$finish;
	end

	initial begin
		int n;
		int n_eff;
		int m;
		int phase;
		sb = new;
		sb.entry_count = '0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_req       = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		hold_off     = 1'b0;
		in_idle_max  = 19;
		out_idle_max = 19;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_count(0);
		search_key(0);
		search_key(32'sh8000_0000);
		search_key(32'sh7FFF_FFFF);

		in_idle_max  = 0;
		out_idle_max = 0;
		load_table(TABLE_DEPTH, 1'b1);
		in_idle_max  = 19;
		out_idle_max = 19;
		write_count(11'd1024);
		search_key(sb.entries[0]);
		search_key(sb.entries[TABLE_DEPTH - 1]);
		search_key(sb.entries[511]);
		search_key(sb.entries[700] + 1);
		search_key($urandom);
		write_count(11'd2047);
		search_key(sb.entries[TABLE_DEPTH - 1]);
		search_key(sb.entries[0]);
		write_count(11'd1);
		search_key(sb.entries[0]);
		search_key(sb.entries[TABLE_DEPTH - 1]);
		write_entry(1023, $urandom);

		random_items = 0;
		big_loads    = 0;
		phase        = 0;
		while (random_items < 400) begin
			in_idle_max  = ($urandom % 3 == 0) ? 0 : 19;
			out_idle_max = ($urandom % 3 == 0) ? 0 : 19;
			case ($urandom % 10)
				0: n = 0;
				1: begin
					if (big_loads < 2) begin
						load_table(TABLE_DEPTH, 1'b0);
						big_loads++;
					end
					case ($urandom % 4)
						0: n = 1023;
						1: n = 1024;
						2: n = 2047;
						default: n = $urandom_range(2046, 1025);
					endcase
				end
				2: n = 1;
				3: n = 2;
				default: n = $urandom_range(40, 3);
			endcase
			if (n > 0 && n < TABLE_DEPTH)
				load_table(n, 1'b0);
			write_count(n[CNT_W-1:0]);
			n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
			if (phase == 2) begin
				in_idle_max = 0;
				fork
					begin
						hold_off <= 1'b1;
						repeat (400) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			m = $urandom_range(24, 8);
			for (int j = 0; j < m; j++) begin
				if ($urandom % 10 == 0)
					write_entry($urandom_range(TABLE_DEPTH - 1, 0), $urandom);
				else
					search_key(pick_key(n_eff));
				random_items++;
			end
			phase++;
		end

		drain();
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("binary_search_engine_tb: done, clean");
		else
			$display("binary_search_engine_tb: done, errors");
		$finish;
	end

endmodule
